// ===== rtl/htxfr_pkg.sv =====
// ----------------------------------------------------------------------------
// htxfr_pkg
// Shared types and constants for the header/trailer XOR frame receiver.
// ----------------------------------------------------------------------------
package htxfr_pkg;

  // Frame delimiters and the control frame type
  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'h7E;
  localparam logic [7:0] TRL_FIRST  = 8'h7E;
  localparam logic [7:0] TRL_SECOND = 8'h55;
  localparam logic [7:0] TYPE_CTRL  = 8'h01;

  // Result beat layout
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  // Frame status codes
  typedef enum logic [1:0] {
    STAT_GOOD    = 2'd0,
    STAT_TRAILER = 2'd1,
    STAT_CHKSUM  = 2'd2
  } frame_status_t;

  // Position within a frame; one state per byte offset
  typedef enum logic [3:0] {
    ST_HUNT = 4'd0,
    ST_HDR2 = 4'd1,
    ST_TYPE = 4'd2,
    ST_B3   = 4'd3,
    ST_B4   = 4'd4,
    ST_B5   = 4'd5,
    ST_B6   = 4'd6,
    ST_CHK  = 4'd7,
    ST_TRL1 = 4'd8,
    ST_TRL2 = 4'd9
  } rx_state_t;

endpackage

// ===== rtl/header_trailer_xor_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// header_trailer_xor_frame_receiver
// Byte-serial receiver for 10-byte frames 55 7E type b3 b4 b5 b6 chk 7E 55.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while in_tready is high. The position
// state machine, a running XOR and a handful of held bytes are updated as
// each byte is accepted; on the tenth byte the status is worked out in the
// same cycle and registered into the result stage. Only the last frame byte
// waits on the result stage: if a previous result is still unaccepted there,
// in_tready drops for that byte alone. Status: 0 good, 1 trailer mismatch
// (checked first), 2 checksum mismatch. A good frame of type 0x01 latches b3
// as steer angle and b5 as drive speed; the latched values go out with every
// result.
module header_trailer_xor_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] frame_type, [15:8] computed_checksum, [16] control_updated,
  // [24:17] steer_angle, [32:25] drive_speed, [39:33] zero
  output logic [htxfr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [htxfr_pkg::OUT_USER_W-1:0] out_tuser  // [1:0] frame_status
);

  htxfr_pkg::rx_state_t state_r, state_nxt;

  logic [7:0] type_r,   type_nxt;
  logic [7:0] angle_r,  angle_nxt;
  logic [7:0] speed_r,  speed_nxt;
  logic [7:0] xor_r,    xor_nxt;
  logic [7:0] chk_r,    chk_nxt;
  logic       trl1_r,   trl1_nxt;
  logic [7:0] lat_angle_r, lat_angle_nxt;
  logic [7:0] lat_speed_r, lat_speed_nxt;

  logic                     out_valid_r, out_valid_nxt;
  htxfr_pkg::frame_status_t out_status_r, out_status_nxt;
  logic [7:0]               out_type_r, out_type_nxt;
  logic [7:0]               out_xor_r, out_xor_nxt;
  logic                     out_upd_r, out_upd_nxt;

  logic                     in_fire;
  logic                     trailer_ok;
  htxfr_pkg::frame_status_t status;
  logic                     update;

  // Stall only the closing byte while a result is still held
  assign in_tready = (state_r != htxfr_pkg::ST_TRL2) || !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Next frame position
  always_comb begin
    state_nxt = state_r;
    if (in_fire) begin
      case (state_r)
        htxfr_pkg::ST_HUNT: begin
          state_nxt = (in_tdata == htxfr_pkg::HDR_FIRST) ? htxfr_pkg::ST_HDR2
                                                         : htxfr_pkg::ST_HUNT;
        end
        htxfr_pkg::ST_HDR2: begin
          if (in_tdata == htxfr_pkg::HDR_SECOND) begin
            state_nxt = htxfr_pkg::ST_TYPE;
          end else if (in_tdata == htxfr_pkg::HDR_FIRST) begin
            state_nxt = htxfr_pkg::ST_HDR2;
          end else begin
            state_nxt = htxfr_pkg::ST_HUNT;
          end
        end
        htxfr_pkg::ST_TYPE: state_nxt = htxfr_pkg::ST_B3;
        htxfr_pkg::ST_B3:   state_nxt = htxfr_pkg::ST_B4;
        htxfr_pkg::ST_B4:   state_nxt = htxfr_pkg::ST_B5;
        htxfr_pkg::ST_B5:   state_nxt = htxfr_pkg::ST_B6;
        htxfr_pkg::ST_B6:   state_nxt = htxfr_pkg::ST_CHK;
        htxfr_pkg::ST_CHK:  state_nxt = htxfr_pkg::ST_TRL1;
        htxfr_pkg::ST_TRL1: state_nxt = htxfr_pkg::ST_TRL2;
        htxfr_pkg::ST_TRL2: state_nxt = htxfr_pkg::ST_HUNT;
        // Unused positions behave as hunting
        default: begin
          state_nxt = (in_tdata == htxfr_pkg::HDR_FIRST) ? htxfr_pkg::ST_HDR2
                                                         : htxfr_pkg::ST_HUNT;
        end
      endcase
    end
  end

  // Frame verdict on the closing byte
  assign trailer_ok = trl1_r && (in_tdata == htxfr_pkg::TRL_SECOND);
  always_comb begin
    update = 1'b0;
    if (!trailer_ok) begin
      status = htxfr_pkg::STAT_TRAILER;
    end else if (xor_r != chk_r) begin
      status = htxfr_pkg::STAT_CHKSUM;
    end else begin
      status = htxfr_pkg::STAT_GOOD;
      update = (type_r == htxfr_pkg::TYPE_CTRL);
    end
  end

  // Field capture and result stage
  always_comb begin
    type_nxt       = type_r;
    angle_nxt      = angle_r;
    speed_nxt      = speed_r;
    xor_nxt        = xor_r;
    chk_nxt        = chk_r;
    trl1_nxt       = trl1_r;
    lat_angle_nxt  = lat_angle_r;
    lat_speed_nxt  = lat_speed_r;
    out_status_nxt = out_status_r;
    out_type_nxt   = out_type_r;
    out_xor_nxt    = out_xor_r;
    out_upd_nxt    = out_upd_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    if (in_fire) begin
      case (state_r)
        htxfr_pkg::ST_TYPE: begin
          type_nxt = in_tdata;
          xor_nxt  = 8'h00;
        end
        htxfr_pkg::ST_B3: begin
          angle_nxt = in_tdata;
          xor_nxt   = xor_r ^ in_tdata;
        end
        htxfr_pkg::ST_B4: xor_nxt = xor_r ^ in_tdata;
        htxfr_pkg::ST_B5: begin
          speed_nxt = in_tdata;
          xor_nxt   = xor_r ^ in_tdata;
        end
        htxfr_pkg::ST_B6:   xor_nxt  = xor_r ^ in_tdata;
        htxfr_pkg::ST_CHK:  chk_nxt  = in_tdata;
        htxfr_pkg::ST_TRL1: trl1_nxt = (in_tdata == htxfr_pkg::TRL_FIRST);
        htxfr_pkg::ST_TRL2: begin
          if (update) begin
            lat_angle_nxt = angle_r;
            lat_speed_nxt = speed_r;
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = status;
          out_type_nxt   = type_r;
          out_xor_nxt    = xor_r;
          out_upd_nxt    = update;
        end
        default: begin
        end
      endcase
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= htxfr_pkg::ST_HUNT;
      type_r       <= 8'h00;
      angle_r      <= 8'h00;
      speed_r      <= 8'h00;
      xor_r        <= 8'h00;
      chk_r        <= 8'h00;
      trl1_r       <= 1'b0;
      lat_angle_r  <= 8'h00;
      lat_speed_r  <= 8'h00;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      type_r       <= type_nxt;
      angle_r      <= angle_nxt;
      speed_r      <= speed_nxt;
      xor_r        <= xor_nxt;
      chk_r        <= chk_nxt;
      trl1_r       <= trl1_nxt;
      lat_angle_r  <= lat_angle_nxt;
      lat_speed_r  <= lat_speed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload holds without reset
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_type_r   <= out_type_nxt;
    out_xor_r    <= out_xor_nxt;
    out_upd_r    <= out_upd_nxt;
  end

  // Drive the result beat; latched values are the live copy
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, lat_speed_r, lat_angle_r, out_upd_r, out_xor_r, out_type_r};

endmodule

// ===== rtl/htxfr_checker.sv =====
// ----------------------------------------------------------------------------
// htxfr_checker
// Port-level checks for the header/trailer XOR frame receiver.
// ----------------------------------------------------------------------------
module htxfr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [htxfr_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [htxfr_pkg::OUT_USER_W-1:0]  out_tuser
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Input never blocks while the result stage is empty
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result stage");

  // An update flag only comes with a good frame
  a_upd_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tuser == htxfr_pkg::STAT_GOOD)
    else $error("control update on a bad frame");

  // Latched controls change only with an updating beat
  a_lat_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_tdata[32:17]) |-> out_tvalid && out_tdata[16])
    else $error("latched controls changed without an update");

  // A rising result valid needs a byte accepted in the previous cycle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result beat without an accepted byte");

endmodule

bind header_trailer_xor_frame_receiver htxfr_checker u_htxfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/header_trailer_xor_frame_receiver_test.sv =====
// ----------------------------------------------------------------------------
// header_trailer_xor_frame_receiver_test
// Self-checking bench for the header/trailer XOR frame receiver.
// ----------------------------------------------------------------------------
// Bytes go in one beat at a time in bursts with random gaps, while the result
// side stalls on a rotating pattern. A behavioural decoder follows every
// accepted byte and queues the result beat due on each tenth frame byte; the
// monitor pops and compares every result beat field by field. Stimulus is a
// short directed sequence, then mostly well-formed frames with random content
// and random faults, then a raw byte stream rich in delimiter values.
module header_trailer_xor_frame_receiver_test;

  typedef struct {
    htxfr_pkg::frame_status_t status;
    logic [7:0]               ftype;
    logic [7:0]               xsum;
    logic                     updated;
    logic [7:0]               angle;
    logic [7:0]               speed;
  } frame_result_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [7:0]                       in_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [htxfr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [htxfr_pkg::OUT_USER_W-1:0] out_tuser;

  // Expected result beats, oldest first
  frame_result_t expected_results[$];
  int            failures    = 0;
  int            burst_left  = 0;
  int            frame_bytes = 0;
  int            stall_phase = 0;

  // Decoder state, mirrors the receiver after reset
  htxfr_pkg::rx_state_t rx_pos = htxfr_pkg::ST_HUNT;
  logic [7:0] type_hold   = '0;
  logic [7:0] angle_hold  = '0;
  logic [7:0] speed_hold  = '0;
  logic [7:0] xor_acc     = '0;
  logic [7:0] chk_hold    = '0;
  logic       trl1_seen   = 1'b0;
  logic [7:0] angle_latch = '0;
  logic [7:0] speed_latch = '0;

  header_trailer_xor_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Guard against a hung run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result-side stalls: rotate through always ready, light, heavy and periodic
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case ((stall_phase / 256) % 4)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ((stall_phase % 13) < 9);
    endcase
  end

  // Advance the decoder by one accepted byte; queue a result on the tenth
  task automatic decode_rx_byte(input logic [7:0] b);
    frame_result_t r;
    logic          trl_ok;
    case (rx_pos)
      htxfr_pkg::ST_HDR2: begin
        if (b == htxfr_pkg::HDR_SECOND)
          rx_pos = htxfr_pkg::ST_TYPE;
        else if (b == htxfr_pkg::HDR_FIRST)
          rx_pos = htxfr_pkg::ST_HDR2;
        else
          rx_pos = htxfr_pkg::ST_HUNT;
      end
      htxfr_pkg::ST_TYPE: begin
        type_hold = b;
        xor_acc   = '0;
        rx_pos    = htxfr_pkg::ST_B3;
      end
      htxfr_pkg::ST_B3: begin
        angle_hold = b;
        xor_acc    = xor_acc ^ b;
        rx_pos     = htxfr_pkg::ST_B4;
      end
      htxfr_pkg::ST_B4: begin
        xor_acc = xor_acc ^ b;
        rx_pos  = htxfr_pkg::ST_B5;
      end
      htxfr_pkg::ST_B5: begin
        speed_hold = b;
        xor_acc    = xor_acc ^ b;
        rx_pos     = htxfr_pkg::ST_B6;
      end
      htxfr_pkg::ST_B6: begin
        xor_acc = xor_acc ^ b;
        rx_pos  = htxfr_pkg::ST_CHK;
      end
      htxfr_pkg::ST_CHK: begin
        chk_hold = b;
        rx_pos   = htxfr_pkg::ST_TRL1;
      end
      htxfr_pkg::ST_TRL1: begin
        trl1_seen = (b == htxfr_pkg::TRL_FIRST);
        rx_pos    = htxfr_pkg::ST_TRL2;
      end
      htxfr_pkg::ST_TRL2: begin
        trl_ok    = trl1_seen && (b == htxfr_pkg::TRL_SECOND);
        r.updated = 1'b0;
        if (!trl_ok) begin
          r.status = htxfr_pkg::STAT_TRAILER;
        end else if (xor_acc != chk_hold) begin
          r.status = htxfr_pkg::STAT_CHKSUM;
        end else begin
          r.status = htxfr_pkg::STAT_GOOD;
          if (type_hold == htxfr_pkg::TYPE_CTRL) begin
            angle_latch = angle_hold;
            speed_latch = speed_hold;
            r.updated   = 1'b1;
          end
        end
        r.ftype = type_hold;
        r.xsum  = xor_acc;
        r.angle = angle_latch;
        r.speed = speed_latch;
        expected_results.push_back(r);
        rx_pos = htxfr_pkg::ST_HUNT;
      end
      default: begin
        rx_pos = (b == htxfr_pkg::HDR_FIRST) ? htxfr_pkg::ST_HDR2 : htxfr_pkg::ST_HUNT;
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      failures++;
      if (failures <= 10)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: tuser 0x%0h tdata 0x%0h", out_tuser, out_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("frame_status", 32'(want.status), 32'(out_tuser[1:0]));
        check_field("frame_type", 32'(want.ftype), 32'(out_tdata[7:0]));
        check_field("computed_checksum", 32'(want.xsum), 32'(out_tdata[15:8]));
        check_field("control_updated", 32'(want.updated), 32'(out_tdata[16]));
        check_field("steer_angle", 32'(want.angle), 32'(out_tdata[24:17]));
        check_field("drive_speed", 32'(want.speed), 32'(out_tdata[32:25]));
        check_field("tdata padding", 0, 32'(out_tdata[39:33]));
      end
    end
  end

  // Send one byte beat; open a new burst with an optional gap when one runs out
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    decode_rx_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] b3,
                            input logic [7:0] b4, input logic [7:0] b5,
                            input logic [7:0] b6, input logic [7:0] chk,
                            input logic [7:0] t1, input logic [7:0] t2);
    send_byte(htxfr_pkg::HDR_FIRST);
    send_byte(htxfr_pkg::HDR_SECOND);
    send_byte(ftype);
    send_byte(b3);
    send_byte(b4);
    send_byte(b5);
    send_byte(b6);
    send_byte(chk);
    send_byte(t1);
    send_byte(t2);
    frame_bytes += 10;
  endtask

  // Hold the sender off until every queued result has come out
  task automatic wait_results_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Noise, a repeated header byte, a good control frame at the field extremes,
  // then a frame with the header in its body and both trailer and checksum bad
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(htxfr_pkg::HDR_FIRST);
    send_frame(htxfr_pkg::TYPE_CTRL, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h7F,
               htxfr_pkg::TRL_FIRST, htxfr_pkg::TRL_SECOND);
    send_frame(8'h00, htxfr_pkg::HDR_FIRST, htxfr_pkg::HDR_SECOND, htxfr_pkg::TYPE_CTRL,
               8'hAA, 8'h00, htxfr_pkg::TRL_SECOND, htxfr_pkg::TRL_FIRST);
  endtask

  // Mostly well-formed frames with random content, some with injected faults
  task automatic test_random_frames();
    logic [7:0] ftype, b3, b4, b5, b6, chk, t1, t2, noise;
    int         kind;
    int         frames;
    frames = 0;
    while (frame_bytes < 1400) begin
      // Leading noise; keep a header second byte out so framing stays aligned
      repeat ($urandom_range(0, 2)) begin
        noise = 8'($urandom_range(0, 255));
        if (noise == htxfr_pkg::HDR_SECOND)
          noise = htxfr_pkg::HDR_FIRST;
        send_byte(noise);
      end
      kind  = $urandom_range(0, 9);
      ftype = ($urandom_range(0, 1) == 0) ? htxfr_pkg::TYPE_CTRL
                                          : 8'($urandom_range(0, 255));
      b3    = 8'($urandom_range(0, 255));
      b4    = 8'($urandom_range(0, 255));
      b5    = 8'($urandom_range(0, 255));
      b6    = 8'($urandom_range(0, 255));
      chk   = b3 ^ b4 ^ b5 ^ b6;
      t1    = htxfr_pkg::TRL_FIRST;
      t2    = htxfr_pkg::TRL_SECOND;
      case (kind)
        6: chk = chk ^ 8'($urandom_range(1, 255));
        7: t1  = htxfr_pkg::TRL_FIRST ^ 8'($urandom_range(1, 255));
        8: t2  = htxfr_pkg::TRL_SECOND ^ 8'($urandom_range(1, 255));
        9: begin
          t1 = 8'($urandom_range(0, 255));
          t2 = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1) == 0)
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        default: ;
      endcase
      send_frame(ftype, b3, b4, b5, b6, chk, t1, t2);
      frames++;
      if (frames % 50 == 0)
        wait_results_drained();
    end
  endtask

  // Raw stream weighted towards delimiter values: partial headers, early
  // starts and misaligned frames
  task automatic test_broken_stream();
    logic [7:0] b;
    repeat (250) begin
      case ($urandom_range(0, 3))
        0:       b = htxfr_pkg::HDR_FIRST;
        1:       b = htxfr_pkg::HDR_SECOND;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
  endtask

  initial begin
    int waited;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_results_drained();
    test_random_frames();
    wait_results_drained();
    test_broken_stream();

    // Drain remaining results, then allow the block's latency to pass
    in_tvalid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      failures += expected_results.size();
      $display("%0d expected result beats never arrived", expected_results.size());
    end

    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/htxfr_pkg.sv
rtl/header_trailer_xor_frame_receiver.sv
rtl/htxfr_checker.sv
test/header_trailer_xor_frame_receiver_test.sv
